// ----- rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and widths for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W     = 16;
  localparam int SQRT_FRAC  = 15;
  // result scale 2^16 against divisor scale 2*2^15 cancels: q = |N| / |a|
  localparam int MAG_W      = 33;   // |b^2 - 4ac|
  localparam int ROOT_W     = 32;   // floor(sqrt(|d| * 2^30))
  localparam int SREM_W     = 35;
  localparam int SX_W       = 64;   // radicand width
  localparam int NUM_W      = 33;   // numerator magnitude
  localparam int QUO_W      = 33;
  localparam int DREM_W     = 17;
  localparam int OUT_W      = 40;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef enum logic [1:0] {
    KIND_REAL  = 2'd0,
    KIND_CPLX  = 2'd1,
    KIND_REP   = 2'd2,
    KIND_DEGEN = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [MAG_W-1:0]          mag;
    logic signed [COEF_W-1:0]  coef_b;
    logic                      a_neg;
    logic [COEF_W-1:0]         a_mag;
  } job_t;

  typedef struct packed {
    job_t               job;
    logic [SREM_W-1:0]  rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

  typedef struct packed {
    kind_t              kind;
    logic               neg1;
    logic               neg2;
    logic [COEF_W-1:0]  den;
    logic [NUM_W-1:0]   n1;
    logic [NUM_W-1:0]   n2;
    logic [DREM_W-1:0]  r1;
    logic [DREM_W-1:0]  r2;
    logic [QUO_W-1:0]   q1;
    logic [QUO_W-1:0]   q2;
  } dv_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ----- rtl/quadratic_root_solver.sv -----
// Throughput: one coefficient word per cycle while in_stall is low; the back
// end is fully pipelined (32-stage root, 33-stage two-lane divider) and a
// 4-entry queue decouples it.
// Reset: synchronous active-low rst_n clears valid flags and queue pointers.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0, Q8.8 in, Q23.16 out.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coef_a,
  input  logic signed [COEF_W-1:0] in_coef_b,
  input  logic signed [COEF_W-1:0] in_coef_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_root_kind,
  output logic signed [OUT_W-1:0]  out_first_value,
  output logic signed [OUT_W-1:0]  out_second_value
);

  qctl_t             qctl;
  job_t              f_job, q_job, s_job;
  logic              q_full, q_empty, q_pop, back_en;
  logic              s_vld, d_vld;
  logic [ROOT_W-1:0] s_root;
  dv_t               nm_r, nm_nxt, d_out;
  logic              nm_vld_r;
  logic signed [34:0] nb, sv, n1, n2, a1, a2;
  logic               out_valid_r;
  kind_t              kind_r;
  logic signed [OUT_W-1:0] v1_r, v2_r, v1_nxt, v2_nxt;

  assign back_en = !out_valid_r || !out_stall;
  assign q_pop   = back_en && !q_empty;

  qrs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_coef_a, .in_coef_b, .in_coef_c,
    .qctl, .q_full, .job(f_job)
  );

  qrs_queue u_queue (
    .clk, .rst_n, .push(qctl.push), .push_data(f_job), .full(q_full),
    .pop(q_pop), .pop_data(q_job), .empty(q_empty)
  );

  qrs_sqrt u_sqrt (
    .clk, .rst_n, .en(back_en), .in_vld(!q_empty), .in_job(q_job),
    .out_vld(s_vld), .out_job(s_job), .out_root(s_root)
  );

  // numerators: -b*2^15 and the root, both with 15 fraction bits
  always_comb begin
    nb = -$signed({{4{s_job.coef_b[COEF_W-1]}}, s_job.coef_b, {SQRT_FRAC{1'b0}}});
    sv = $signed({3'b0, s_root});
    case (s_job.kind)
      KIND_REAL: begin
        n1 = nb - sv;
        n2 = nb + sv;
      end
      KIND_CPLX: begin
        n1 = nb;
        n2 = sv;
      end
      default: begin
        n1 = nb;
        n2 = nb;
      end
    endcase
    a1 = n1[34] ? -n1 : n1;
    a2 = n2[34] ? -n2 : n2;
    nm_nxt      = '0;
    nm_nxt.kind = s_job.kind;
    nm_nxt.neg1 = n1[34] ^ s_job.a_neg;
    nm_nxt.neg2 = n2[34] ^ s_job.a_neg;
    nm_nxt.den  = s_job.a_mag;
    nm_nxt.n1   = a1[NUM_W-1:0];
    nm_nxt.n2   = a2[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (back_en) nm_r <= nm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       nm_vld_r <= 1'b0;
    else if (back_en) nm_vld_r <= s_vld;
  end

  qrs_div u_div (
    .clk, .rst_n, .en(back_en), .in_vld(nm_vld_r), .in_dv(nm_r),
    .out_vld(d_vld), .out_dv(d_out)
  );

  // quotient stays below 2^33, so the 40-bit limits are never reached
  always_comb begin
    v1_nxt = d_out.neg1 ? -$signed({7'b0, d_out.q1}) : $signed({7'b0, d_out.q1});
    v2_nxt = d_out.neg2 ? -$signed({7'b0, d_out.q2}) : $signed({7'b0, d_out.q2});
    if (d_out.kind == KIND_DEGEN) begin
      v1_nxt = '0;
      v2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       out_valid_r <= 1'b0;
    else if (back_en) out_valid_r <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      kind_r <= d_out.kind;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_kind    = kind_r;
  assign out_first_value  = v1_r;
  assign out_second_value = v2_r;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_DEGEN |-> out_first_value == '0 &&
    out_second_value == '0) else $error("degenerate result not zero");

  a_rep_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_REP |-> out_first_value == out_second_value)
    else $error("repeated root values differ");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !back_en |-> !q_pop) else $error("queue popped while back end stalled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    qctl.full |-> !qctl.push) else $error("queue pushed while full");
`endif

endmodule

// ----- rtl/qrs_queue.sv -----
// ----------------------------------------------------------------------------
// qrs_queue
// Short queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module qrs_queue import qrs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_data,
  output logic  full,
  input  logic  pop,
  output job_t  pop_data,
  output logic  empty
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- rtl/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient words, forms the discriminant and classifies the roots.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coef_a,
  input  logic signed [COEF_W-1:0] in_coef_b,
  input  logic signed [COEF_W-1:0] in_coef_c,
  output qctl_t                    qctl,
  input  logic                     q_full,
  output job_t                     job
);

  logic                     vld_r;
  logic signed [31:0]       bb_r, ac_r, bb_nxt, ac_nxt;
  logic signed [COEF_W-1:0] a_r, b_r;
  logic signed [34:0]       d;
  logic [34:0]              d_abs;

  assign bb_nxt    = in_coef_b * in_coef_b;
  assign ac_nxt    = in_coef_a * in_coef_c;
  assign in_stall  = vld_r && q_full;
  assign qctl.push = vld_r && !q_full;
  assign qctl.full = q_full;

  always_comb begin
    d     = 35'(bb_r) - (35'(ac_r) <<< 2);
    d_abs = d[34] ? 35'(-d) : 35'(d);
    job.mag    = d_abs[MAG_W-1:0];
    job.coef_b = b_r;
    job.a_neg  = a_r[COEF_W-1];
    job.a_mag  = a_r[COEF_W-1] ? COEF_W'(-a_r) : COEF_W'(a_r);
    if (a_r == '0)    job.kind = KIND_DEGEN;
    else if (d == '0) job.kind = KIND_REP;
    else if (d[34])   job.kind = KIND_CPLX;
    else              job.kind = KIND_REAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      bb_r <= bb_nxt;
      ac_r <= ac_nxt;
      a_r  <= in_coef_a;
      b_r  <= in_coef_b;
    end
  end

endmodule

// ----- rtl/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined square root of |d| * 2^30, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  job_t              in_job,
  output logic              out_vld,
  output job_t              out_job,
  output logic [ROOT_W-1:0] out_root
);

  sq_t  st_r  [ROOT_W];
  logic vld_r [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_st
    sq_t               cur, nxt;
    logic [SX_W-1:0]   x;
    logic [SREM_W-1:0] rem_s, trial;

    if (k == 0) begin : g_first
      assign cur = {in_job, {SREM_W{1'b0}}, {ROOT_W{1'b0}}};
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    always_comb begin
      x     = {1'b0, cur.job.mag, {(2*SQRT_FRAC){1'b0}}};
      rem_s = {cur.rem[SREM_W-3:0], x[2*(ROOT_W-1-k)+1 -: 2]};
      trial = {1'b0, cur.root, 2'b01};
      nxt   = cur;
      if (rem_s >= trial) begin
        nxt.rem  = rem_s - trial;
        nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_s;
        nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) st_r[k] <= nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        if (k == 0) vld_r[k] <= in_vld;
        else        vld_r[k] <= vld_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_job  = st_r[ROOT_W-1].job;
  assign out_root = st_r[ROOT_W-1].root;

endmodule

// ----- rtl/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  dv_t  in_dv,
  output logic out_vld,
  output dv_t  out_dv
);

  dv_t  st_r  [QUO_W];
  logic vld_r [QUO_W];

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_st
    dv_t               cur, nxt;
    logic [DREM_W-1:0] rs1, rs2, dd;

    if (k == 0) begin : g_first
      assign cur = in_dv;
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    always_comb begin
      dd  = {1'b0, cur.den};
      rs1 = {cur.r1[DREM_W-2:0], cur.n1[NUM_W-1]};
      rs2 = {cur.r2[DREM_W-2:0], cur.n2[NUM_W-1]};
      nxt = cur;
      nxt.n1 = {cur.n1[NUM_W-2:0], 1'b0};
      nxt.n2 = {cur.n2[NUM_W-2:0], 1'b0};
      if (rs1 >= dd) begin
        nxt.r1 = rs1 - dd;
        nxt.q1 = {cur.q1[QUO_W-2:0], 1'b1};
      end else begin
        nxt.r1 = rs1;
        nxt.q1 = {cur.q1[QUO_W-2:0], 1'b0};
      end
      if (rs2 >= dd) begin
        nxt.r2 = rs2 - dd;
        nxt.q2 = {cur.q2[QUO_W-2:0], 1'b1};
      end else begin
        nxt.r2 = rs2;
        nxt.q2 = {cur.q2[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) st_r[k] <= nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        if (k == 0) vld_r[k] <= in_vld;
        else        vld_r[k] <= vld_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_dv  = st_r[QUO_W-1];

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quadratic_root_solver. Coefficient words go in
// through a randomly idling sender. Results leave through a randomly stalling
// receiver. Each result is checked against a bit-exact fixed-point root
// predictor, oldest expectation first.
// ----------------------------------------------------------------------------
module tb_top import qrs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t             kind;
    logic [OUT_W-1:0]  first;
    logic [OUT_W-1:0]  second;
  } roots_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [COEF_W-1:0] in_coef_a;
  logic signed [COEF_W-1:0] in_coef_b;
  logic signed [COEF_W-1:0] in_coef_c;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_root_kind;
  logic signed [OUT_W-1:0]  out_first_value;
  logic signed [OUT_W-1:0]  out_second_value;

  roots_t expected_roots[$];
  int     fail_count;
  int     idle_cycles;
  bit     hold_req;
  bit     no_gap;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;

  quadratic_root_solver dut (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] probe;
    r = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= r + probe) begin
        v = v - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  // num carries 15 fraction bits; result is Q23.16 truncated toward zero
  function automatic logic [OUT_W-1:0] root_div(logic signed [63:0] num,
                                                logic signed [63:0] a);
    logic        neg;
    logic [63:0] mn, ma, den, q;
    neg = (num < 0) != (a < 0);
    mn  = num < 0 ? -num : num;
    ma  = a < 0 ? -a : a;
    den = (ma * 2) << SQRT_FRAC;
    q   = (mn << 16) / den;
    if (neg) begin
      if (q > (64'd1 << 39)) q = 64'd1 << 39;
      q = -q;
    end else if (q > (64'd1 << 39) - 1) begin
      q = (64'd1 << 39) - 1;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] ca,
                                         logic signed [15:0] cb,
                                         logic signed [15:0] cc);
    roots_t            res;
    logic signed [63:0] a, b, c, d, nb;
    logic [63:0]       mag, s;
    a = ca; b = cb; c = cc;
    if (a == 0) begin
      res.kind = KIND_DEGEN; res.first = '0; res.second = '0;
      return res;
    end
    d   = b * b - 4 * a * c;
    mag = d < 0 ? -d : d;
    s   = int_sqrt(mag << (2 * SQRT_FRAC));
    nb  = -(b <<< SQRT_FRAC);
    if (d > 0) begin
      res.kind   = KIND_REAL;
      res.first  = root_div(nb - $signed(s), a);
      res.second = root_div(nb + $signed(s), a);
    end else if (d < 0) begin
      res.kind   = KIND_CPLX;
      res.first  = root_div(nb, a);
      res.second = root_div($signed(s), a);
    end else begin
      res.kind   = KIND_REP;
      res.first  = root_div(nb, a);
      res.second = res.first;
    end
    return res;
  endfunction

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (in_stall);
    expected_roots.push_back(solve_roots(a, b, c));
  endtask

  // a*(x-r1)*(x-r2) with small integers keeps the word in range
  task automatic send_from_roots(int a, int r1, int r2);
    send_coefs(16'(a), 16'(-a * (r1 + r2)), 16'(a * r1 * r2));
  endtask

  task automatic test_degenerate();
    send_coefs(16'sh0000, 16'sh0000, 16'sh0000);
    send_coefs(16'sh0000, 16'sh7fff, 16'sh8000);
    send_coefs(16'sh0000, 16'sh8000, 16'sh7fff);
    send_coefs(16'sh0000, 16'shffff, 16'shffff);
  endtask

  task automatic test_extremes();
    send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
    send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
    send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh0001, 16'sh8000, 16'sh0000);
    send_coefs(16'sh0001, 16'sh7fff, 16'sh7fff);
    send_coefs(16'shffff, 16'sh8000, 16'sh8000);
    send_coefs(16'sh0001, 16'sh0000, 16'sh8000);
    send_coefs(16'sh8000, 16'sh0000, 16'sh7fff);
    send_coefs(16'shffff, 16'sh0001, 16'shffff);
  endtask

  task automatic test_root_kinds();
    send_from_roots(1, 3, -2);     // real distinct
    send_from_roots(-5, 7, 1);
    send_from_roots(4, -3, -3);    // repeated
    send_from_roots(-2, 6, 6);
    send_coefs(16'sh0100, 16'sh0000, 16'sh0100);  // complex, a > 0
    send_coefs(16'shff00, 16'sh0200, 16'shfc00);  // complex, a < 0
    send_coefs(16'sh0100, 16'sh0200, 16'sh0100);  // repeated in Q8.8
  endtask

  task automatic test_random(int count);
    int sel, a, r1, r2;
    repeat (count) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        send_coefs(16'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 5) begin
        a  = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1);
        r1 = $urandom_range(0, 30) - 15;
        r2 = $urandom_range(0, 1) ? r1 : $urandom_range(0, 30) - 15;
        send_from_roots(a, r1, r2);
      end else if (sel < 7) begin
        // complex when b^2 < 4ac: a, c of one sign and a small b
        a = $urandom_range(1, 32767);
        if ($urandom_range(0, 1)) begin
          send_coefs(16'(a), 16'($urandom_range(0, 400) - 200),
                     16'($urandom_range(200, 32767)));
        end else begin
          send_coefs(16'(-a), 16'($urandom_range(0, 400) - 200),
                     16'(-$urandom_range(200, 32768)));
        end
      end else if (sel < 9) begin
        send_coefs(16'($urandom_range(0, 8) - 4), 16'($urandom),
                   16'($urandom));
      end else begin
        send_coefs(16'sh0000, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gap   = 1'b1;
    test_random(40);
    no_gap   = 1'b0;
  endtask

  // receiver: random stall per word, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) n = 0;
      end
      out_stall <= (n != 0);
      if (n != 0) begin
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    roots_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result word: kind %0d", out_root_kind);
          fail_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (out_root_kind != exp_r.kind) begin
            $error("root_kind: expected %0d, got %0d", exp_r.kind, out_root_kind);
            fail_count++;
          end
          if (out_first_value != exp_r.first) begin
            $error("first_value: expected %0d, got %0d",
                   $signed(exp_r.first), out_first_value);
            fail_count++;
          end
          if (out_second_value != exp_r.second) begin
            $error("second_value: expected %0d, got %0d",
                   $signed(exp_r.second), out_second_value);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    fail_count  = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    no_gap      = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_coef_a   = '0;
    in_coef_b   = '0;
    in_coef_c   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degenerate();
    test_extremes();
    test_root_kinds();
    test_random(400);
    test_backpressure();
    test_random(460);
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
